[rtl/gcsa_pkg.sv]
`timescale 1ns / 1ps

package gcsa_pkg;

	localparam int SLOTS      = 64;
	localparam int GEN_BITS   = 16;
	localparam int COUNT_BITS = 16;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int SUM_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [2:0] FN_ALLOC   = 3'd0;
	localparam logic [2:0] FN_RETAIN  = 3'd1;
	localparam logic [2:0] FN_RELEASE = 3'd2;
	localparam logic [2:0] FN_INC     = 3'd3;
	localparam logic [2:0] FN_DEC     = 3'd4;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_NOFREE = 3'd1;
	localparam logic [2:0] ST_STALE  = 3'd2;
	localparam logic [2:0] ST_UNDER  = 3'd3;
	localparam logic [2:0] ST_OVER   = 3'd4;

	typedef struct packed {
		logic [2:0]  func;
		logic [5:0]  slot;
		logic [15:0] handle_generation;
		logic [15:0] amount;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  out_slot;
		logic [15:0] out_generation;
		logic [15:0] value_now;
		logic        reached_zero;
		logic        slot_freed;
	} rsp_t;

	// free stack entry: slot index and the generation it was released with
	typedef struct packed {
		logic [IDX_W-1:0]    idx;
		logic [GEN_BITS-1:0] gen;
	} stk_ent_t;

endpackage

[rtl/generational_counter_slot_allocator.sv]
`timescale 1ns / 1ps

// Generational handle allocator with reference-counted counter slots. One
// transaction is taken per cycle unless the response stalls; it passes an
// input register with synchronous table reads, then one pass of update logic
// into the result register. Each transaction reads and writes one slot of the
// generation, reference and value tables plus the free stack top; writes of
// the transaction in flight are bypassed into the reads of the next one, so
// back-to-back transactions on the same slot need no bubble. Allocation
// returns free slots last-in first-out, slot 0 first after reset. No clearing
// pass is needed after reset.
module generational_counter_slot_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  gcsa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output gcsa_pkg::rsp_t rsp
);
	import gcsa_pkg::*;

	// handshake
	logic acc, adv, fire;
	logic valid_s1, rsp_valid_q;
	req_t req_s1;
	rsp_t rsp_q, rsp_n;

	// tables
	logic [GEN_BITS-1:0]   gen_mem [SLOTS];
	logic [COUNT_BITS-1:0] ref_mem [SLOTS];
	logic [COUNT_BITS-1:0] val_mem [SLOTS];
	stk_ent_t              stk_mem [SLOTS];
	logic [SLOTS-1:0]      live_q, gen_wr_q, stk_wr_q;
	logic [CNT_W-1:0]      count_q, count_n;

	// reads for the transaction in stage 1
	logic [IDX_W-1:0]      raddr;
	logic [GEN_BITS-1:0]   gen_rd_s1;
	logic                  gen_ok_s1;
	logic [COUNT_BITS-1:0] ref_rd_s1, val_rd_s1;

	// free stack top
	logic [IDX_W-1:0] top_addr, top_addr_q;
	logic             top_byp_q, top_vld_q;
	stk_ent_t         top_new_q, stk_rd_q, top;

	// writes from stage 1
	logic                  gen_we, ref_we, val_we, stk_we, push, pop;
	logic [IDX_W-1:0]      gen_waddr, ref_waddr, val_waddr;
	logic [GEN_BITS-1:0]   gen_wdata;
	logic [COUNT_BITS-1:0] ref_wdata, val_wdata;
	stk_ent_t              stk_wdata;

	// stage 1 decode
	logic [IDX_W-1:0]      sidx;
	logic [GEN_BITS-1:0]   hgen, gen_cur, gen_inc;
	logic                  stale;
	logic [SUM_W-1:0]      sum, amt_x, val_x;
	logic [COUNT_BITS-1:0] val_dec;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign fire      = valid_s1 && adv;
	assign req_stall = valid_s1 && !adv;
	assign acc       = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign raddr = IDX_W'(req.slot);

	always_comb begin
		top = top_new_q;
		if (!top_byp_q) begin
			if (top_vld_q) begin
				top = stk_rd_q;
			end else begin
				top.idx = IDX_W'(SLOTS - 1) - top_addr_q;
				top.gen = '0;
			end
		end
	end

	assign sidx    = IDX_W'(req_s1.slot);
	assign hgen    = GEN_BITS'(req_s1.handle_generation);
	assign gen_cur = gen_ok_s1 ? gen_rd_s1 : '0;
	assign gen_inc = gen_cur + 1'b1;
	assign stale   = !(int'(req_s1.slot) < SLOTS) || !live_q[sidx] || (gen_cur != hgen);
	assign amt_x   = SUM_W'(req_s1.amount);
	assign val_x   = SUM_W'(val_rd_s1);
	assign sum     = val_x + amt_x;
	assign val_dec = val_rd_s1 - COUNT_BITS'(req_s1.amount);

	always_comb begin
		rsp_n     = '0;
		gen_we    = 1'b0;
		ref_we    = 1'b0;
		val_we    = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		gen_waddr = sidx;
		ref_waddr = sidx;
		val_waddr = sidx;
		gen_wdata = gen_inc;
		ref_wdata = ref_rd_s1;
		val_wdata = val_rd_s1;
		case (req_s1.func)
			FN_ALLOC: begin
				if (count_q == '0) begin
					rsp_n.status = ST_NOFREE;
				end else begin
					pop       = 1'b1;
					gen_we    = 1'b1;
					ref_we    = 1'b1;
					val_we    = 1'b1;
					gen_waddr = top.idx;
					ref_waddr = top.idx;
					val_waddr = top.idx;
					gen_wdata = top.gen + 1'b1;
					ref_wdata = COUNT_BITS'(1);
					val_wdata = '0;
					rsp_n.out_slot       = 6'(top.idx);
					rsp_n.out_generation = 16'(top.gen + 1'b1);
				end
			end
			FN_RETAIN, FN_RELEASE, FN_INC, FN_DEC: begin
				rsp_n.out_slot = req_s1.slot;
				if (stale) begin
					rsp_n.status = ST_STALE;
				end else begin
					rsp_n.value_now = 16'(val_rd_s1);
					case (req_s1.func)
						FN_RETAIN: begin
							ref_we = 1'b1;
							if (ref_rd_s1 == COUNT_MAX) begin
								rsp_n.status = ST_OVER;
							end else begin
								ref_wdata = ref_rd_s1 + 1'b1;
							end
						end
						FN_RELEASE: begin
							ref_we = 1'b1;
							if (ref_rd_s1 <= COUNT_BITS'(1)) begin
								ref_wdata        = '0;
								gen_we           = 1'b1;
								push             = int'(count_q) < SLOTS;
								rsp_n.slot_freed = 1'b1;
							end else begin
								ref_wdata = ref_rd_s1 - 1'b1;
							end
						end
						FN_INC: begin
							val_we = 1'b1;
							if (sum > SUM_W'(COUNT_MAX)) begin
								val_wdata    = COUNT_MAX;
								rsp_n.status = ST_OVER;
							end else begin
								val_wdata = COUNT_BITS'(sum);
							end
							rsp_n.value_now = 16'(val_wdata);
						end
						default: begin
							if (amt_x > val_x) begin
								rsp_n.status = ST_UNDER;
							end else begin
								val_we             = 1'b1;
								val_wdata          = val_dec;
								rsp_n.value_now    = 16'(val_dec);
								rsp_n.reached_zero = (val_rd_s1 != '0) && (val_dec == '0);
							end
						end
					endcase
				end
			end
			default: begin
				rsp_n = '0;
			end
		endcase
	end

	assign stk_we        = fire && push;
	assign stk_wdata.idx = sidx;
	assign stk_wdata.gen = gen_inc;

	always_comb begin
		count_n = count_q;
		if (pop) begin
			count_n = count_q - 1'b1;
		end else if (push) begin
			count_n = count_q + 1'b1;
		end
	end

	assign top_addr = IDX_W'(count_n - 1'b1);

	// tables: synchronous reads with bypass of the write in flight
	always_ff @(posedge clk) begin
		if (fire && gen_we) begin
			gen_mem[gen_waddr] <= gen_wdata;
		end
		if (fire && ref_we) begin
			ref_mem[ref_waddr] <= ref_wdata;
		end
		if (fire && val_we) begin
			val_mem[val_waddr] <= val_wdata;
		end
		if (acc) begin
			gen_rd_s1 <= (fire && gen_we && gen_waddr == raddr) ? gen_wdata : gen_mem[raddr];
			ref_rd_s1 <= (fire && ref_we && ref_waddr == raddr) ? ref_wdata : ref_mem[raddr];
			val_rd_s1 <= (fire && val_we && val_waddr == raddr) ? val_wdata : val_mem[raddr];
			req_s1    <= req;
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[count_q[IDX_W-1:0]] <= stk_wdata;
		end
		if (fire) begin
			stk_rd_q <= stk_mem[top_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			gen_ok_s1   <= 1'b0;
			live_q      <= '0;
			gen_wr_q    <= '0;
			stk_wr_q    <= '0;
			count_q     <= CNT_W'(SLOTS);
			top_byp_q   <= 1'b1;
			top_vld_q   <= 1'b0;
			top_addr_q  <= '0;
			top_new_q   <= '0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (adv) begin
				rsp_valid_q <= valid_s1;
			end
			if (acc) begin
				gen_ok_s1 <= (fire && gen_we && gen_waddr == raddr) || gen_wr_q[raddr];
			end
			if (fire) begin
				if (gen_we) begin
					gen_wr_q[gen_waddr] <= 1'b1;
				end
				if (pop) begin
					live_q[top.idx] <= 1'b1;
				end
				if (push || (req_s1.func == FN_RELEASE && gen_we)) begin
					live_q[sidx] <= 1'b0;
				end
				if (push) begin
					stk_wr_q[count_q[IDX_W-1:0]] <= 1'b1;
				end
				count_q    <= count_n;
				// hold the new top: the pushed entry, or the stack entry below
				top_byp_q  <= push;
				top_new_q  <= stk_wdata;
				top_vld_q  <= stk_wr_q[top_addr];
				top_addr_q <= top_addr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_n;
		end
	end

endmodule
